### design/kaa_pkg.sv
package kaa_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DIST_W  = 34;
  localparam int SUM_W   = 48;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 4;
  localparam int CI_W    = 3;
  localparam int DI_W    = 2;

  localparam logic [CFG_W-1:0]   CFG_CLUSTERS_RESET = 4'd8;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } item_kind_t;

  typedef enum logic {
    RES_ASSIGN   = 1'b0,
    RES_READBACK = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [CI_W-1:0]           cluster_index;
    logic [DI_W-1:0]           dim_index;
    logic signed [COORD_W-1:0] coord_value;
    logic                      last_coord;
  } in_item_t;

  typedef struct packed {
    logic                      result_kind;
    logic [CI_W-1:0]           assigned_cluster;
    logic [DIST_W-1:0]         min_dist_sq;
    logic signed [SUM_W-1:0]   coord_sum;
    logic [COUNT_W-1:0]        member_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_DIST  = 3'd1,
    S_DRAIN = 3'd2,
    S_ACC   = 3'd3,
    S_OUT   = 3'd4,
    S_READ  = 3'd5
  } ctrl_state_t;

  typedef struct packed {
    logic take_item;
    logic dist_start;
    logic acc_start;
    logic issue;
    logic out_load_point;
    logic out_load_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_point_last;
    logic item_read;
    logic issue_done;
    logic pipe_busy;
  } ctrl_stat_t;

endpackage

### design/kaa_stream_if.sv
interface kaa_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/kaa_ram.sv
module kaa_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

### design/kaa_ctrl.sv
module kaa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  kaa_pkg::ctrl_stat_t stat,
  output kaa_pkg::ctrl_cmd_t  cmd
);
  import kaa_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // The result register can take a new result when it is empty or being drained now.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.item_read) begin
            state_nxt = S_READ;
          end else if (stat.item_point_last) begin
            state_nxt = S_DIST;
          end
        end
      end
      S_DIST: begin
        if (stat.issue_done) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (stat.issue_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT, S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.take_item  = in_valid;
        cmd.dist_start = in_valid && stat.item_point_last;
      end
      S_DIST:  cmd.issue = 1'b1;
      S_DRAIN: cmd.acc_start = !stat.pipe_busy;
      S_ACC:   cmd.issue = 1'b1;
      S_OUT:   cmd.out_load_point = out_free;
      S_READ:  cmd.out_load_read = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load_point || cmd.out_load_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load_point || cmd.out_load_read) |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result is still pending");

  a_point_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.item_point_last) |=> (state_r == S_DIST))
    else $error("last point coordinate did not start the distance search");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT || $past(state_r) == S_READ))
    else $error("result appeared outside an output state");
endmodule

### design/kaa_datapath.sv
module kaa_datapath #(
  parameter int NUM_CLUSTERS = 8,
  parameter int NUM_DIMS     = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kaa_pkg::in_item_t         item,
  input  logic                      cfg_wr_en,
  input  logic [kaa_pkg::CFG_W-1:0] cfg_wr_data,
  input  kaa_pkg::ctrl_cmd_t        cmd,
  output kaa_pkg::ctrl_stat_t       stat,
  output kaa_pkg::out_item_t        result
);
  import kaa_pkg::*;

  localparam int CW     = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int DW     = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int SDEPTH = NUM_CLUSTERS * NUM_DIMS;
  localparam int AW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam logic [DW-1:0] DIM_LAST = DW'(NUM_DIMS - 1);

  // Item decode
  logic          kind_load, kind_point, kind_read, kind_clear;
  logic          ci_ok, di_ok;
  logic [AW-1:0] item_addr;

  // Configuration and active cluster range
  logic [CFG_W-1:0] cfg_clusters_r;
  logic [CW-1:0]    lastc;

  // Point buffer and per-cluster valid flags
  logic [COORD_W-1:0]      pb_r [NUM_DIMS];
  logic [NUM_CLUSTERS-1:0] clus_vld_r;

  // Issue counters
  logic          mode_acc_r;
  logic [DW-1:0] dim_r;
  logic [CW-1:0] clus_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] acc_base;

  // Stage 1: memory data returns
  logic          v1_r, acc1_r, first1_r, last1_r;
  logic [DW-1:0] dim1_r;
  logic [CW-1:0] clus1_r;
  logic [AW-1:0] addr1_r;

  // Stage 2: accumulate and compare
  logic              v2_r, first2_r, last2_r;
  logic [CW-1:0]     clus2_r;
  logic [DIST_W-1:0] prod_r;
  logic [DIST_W-1:0] dacc_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [CW-1:0]     best_r;

  // Readback capture
  logic [CI_W-1:0] rd_ci_r;
  logic            rd_sum_ok_r, rd_cnt_ok_r;

  out_item_t result_r;

  // Memory ports
  logic               cent_we, cent_re;
  logic [COORD_W-1:0] cent_rdata;
  logic               sum_we, sum_re;
  logic [AW-1:0]      sum_raddr;
  logic [SUM_W-1:0]   sum_rdata, sum_wdata;
  logic               cnt_we, cnt_re;
  logic [CW-1:0]      cnt_raddr;
  logic [COUNT_W-1:0] cnt_rdata, cnt_wdata;
  logic               acc_issue;

  // Arithmetic
  logic signed [COORD_W-1:0] pt_sel, cent_val;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIST_W-1:0]  sq;
  logic [DIST_W:0]           dsum;
  logic [DIST_W-1:0]         dtot;
  logic signed [SUM_W-1:0]   old_sum;
  logic signed [SUM_W:0]     sum_wide;
  logic [COUNT_W-1:0]        old_cnt;

  assign kind_load  = (item.kind == KIND_LOAD);
  assign kind_point = (item.kind == KIND_POINT);
  assign kind_read  = (item.kind == KIND_READ);
  assign kind_clear = (item.kind == KIND_CLEAR);
  assign ci_ok      = int'(item.cluster_index) < NUM_CLUSTERS;
  assign di_ok      = int'(item.dim_index) < NUM_DIMS;
  assign item_addr  = AW'(int'(item.cluster_index) * NUM_DIMS + int'(item.dim_index));

  // A zero setting acts as one cluster; a setting above the table size is clamped.
  always_comb begin
    int n_eff;
    n_eff = int'(cfg_clusters_r);
    if (n_eff == 0) begin
      n_eff = 1;
    end else if (n_eff > NUM_CLUSTERS) begin
      n_eff = NUM_CLUSTERS;
    end
    lastc = CW'(n_eff - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_clusters_r <= CFG_CLUSTERS_RESET;
    end else if (cfg_wr_en) begin
      cfg_clusters_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item && kind_point && di_ok) begin
      pb_r[DW'(item.dim_index)] <= item.coord_value;
    end
  end

  assign stat.item_point_last = kind_point && item.last_coord;
  assign stat.item_read       = kind_read;
  assign stat.issue_done      = (dim_r == DIM_LAST) && (mode_acc_r || clus_r == lastc);
  assign stat.pipe_busy       = v1_r || v2_r;

  assign acc_base = AW'(int'(best_r) * NUM_DIMS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_acc_r <= 1'b0;
    end else if (cmd.dist_start) begin
      mode_acc_r <= 1'b0;
    end else if (cmd.acc_start) begin
      mode_acc_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_start) begin
      dim_r  <= '0;
      clus_r <= '0;
      addr_r <= '0;
    end else if (cmd.acc_start) begin
      dim_r  <= '0;
      addr_r <= acc_base;
    end else if (cmd.issue) begin
      addr_r <= addr_r + AW'(1);
      if (dim_r == DIM_LAST) begin
        dim_r  <= '0;
        clus_r <= clus_r + CW'(1);
      end else begin
        dim_r <= dim_r + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r && !acc1_r;
    end
  end

  always_ff @(posedge clk) begin
    acc1_r   <= mode_acc_r;
    first1_r <= (dim_r == '0);
    last1_r  <= (dim_r == DIM_LAST);
    dim1_r   <= dim_r;
    clus1_r  <= clus_r;
    addr1_r  <= addr_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    clus2_r  <= clus1_r;
    prod_r   <= sq;
  end

  // One shared squarer serves every centroid coordinate in turn.
  assign pt_sel   = pb_r[dim1_r];
  assign cent_val = cent_rdata;
  assign diff     = DIFF_W'(cent_val) - DIFF_W'(pt_sel);
  assign sq       = diff * diff;

  assign dsum = {1'b0, dacc_r} + {1'b0, prod_r};
  assign dtot = first2_r ? prod_r : (dsum[DIST_W] ? DIST_MAX : dsum[DIST_W-1:0]);

  always_ff @(posedge clk) begin
    if (v2_r) begin
      dacc_r <= dtot;
      if (last2_r && (clus2_r == '0 || dtot < best_dist_r)) begin
        best_dist_r <= dtot;
        best_r      <= clus2_r;
      end
    end
  end

  // Sums and counts of a cluster whose row flag is clear read as zero.
  assign old_sum  = clus_vld_r[best_r] ? sum_rdata : '0;
  assign sum_wide = (SUM_W+1)'(old_sum) + (SUM_W+1)'(pt_sel);
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_wdata = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_wdata = sum_wide[SUM_W-1:0];
    end
  end

  assign old_cnt   = clus_vld_r[best_r] ? cnt_rdata : '0;
  assign cnt_wdata = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clus_vld_r <= '0;
    end else if (cmd.take_item && kind_clear) begin
      clus_vld_r <= '0;
    end else if (v1_r && acc1_r && last1_r) begin
      clus_vld_r[best_r] <= 1'b1;
    end
  end

  assign acc_issue = cmd.issue && mode_acc_r;

  assign cent_we   = cmd.take_item && kind_load && ci_ok && di_ok;
  assign cent_re   = cmd.issue && !mode_acc_r;
  assign sum_re    = (cmd.take_item && kind_read) || acc_issue;
  assign sum_raddr = acc_issue ? addr_r : item_addr;
  assign sum_we    = v1_r && acc1_r;
  assign cnt_re    = (cmd.take_item && kind_read) || (acc_issue && dim_r == '0);
  assign cnt_raddr = acc_issue ? best_r : CW'(item.cluster_index);
  assign cnt_we    = v1_r && acc1_r && first1_r;

  kaa_ram #(.WIDTH(COORD_W), .DEPTH(SDEPTH)) u_cent_ram (
    .clk     (clk),
    .wr_en   (cent_we),
    .wr_addr (item_addr),
    .wr_data (item.coord_value),
    .rd_en   (cent_re),
    .rd_addr (addr_r),
    .rd_data (cent_rdata)
  );

  kaa_ram #(.WIDTH(SUM_W), .DEPTH(SDEPTH)) u_sum_ram (
    .clk     (clk),
    .wr_en   (sum_we),
    .wr_addr (addr1_r),
    .wr_data (sum_wdata),
    .rd_en   (sum_re),
    .rd_addr (sum_raddr),
    .rd_data (sum_rdata)
  );

  kaa_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_CLUSTERS)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (best_r),
    .wr_data (cnt_wdata),
    .rd_en   (cnt_re),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_item && kind_read) begin
      rd_ci_r     <= item.cluster_index;
      rd_cnt_ok_r <= ci_ok && clus_vld_r[CW'(item.cluster_index)];
      rd_sum_ok_r <= ci_ok && di_ok && clus_vld_r[CW'(item.cluster_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_point) begin
      result_r.result_kind      <= RES_ASSIGN;
      result_r.assigned_cluster <= CI_W'(best_r);
      result_r.min_dist_sq      <= best_dist_r;
      result_r.coord_sum        <= '0;
      result_r.member_count     <= '0;
    end else if (cmd.out_load_read) begin
      result_r.result_kind      <= RES_READBACK;
      result_r.assigned_cluster <= rd_ci_r;
      result_r.min_dist_sq      <= '0;
      result_r.coord_sum        <= rd_sum_ok_r ? sum_rdata : '0;
      result_r.member_count     <= rd_cnt_ok_r ? cnt_rdata : '0;
    end
  end

  assign result = result_r;

  a_stage2_dist_only: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !mode_acc_r)
    else $error("distance stage active during accumulation");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_start |-> (best_r <= lastc))
    else $error("nearest cluster lies beyond the active range");

  a_acc_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && acc1_r && first1_r) |-> (addr1_r == acc_base))
    else $error("accumulation started away from the row of the nearest cluster");
endmodule

### design/kmeans_assign_accumulate.sv
// Loads, clears and point coordinates other than the last are taken in the idle state and start no search.
// A readback result is read from the sum and count memories, then loaded into the result register once it is free.
// A last point coordinate starts a search over the active clusters: one shared squarer steps
// once per centroid coordinate, then one sum memory port updates the row of the nearest cluster.
// One item is in work at a time; the result register holds while the next item is taken.
// Synchronous active-low reset clears control and accumulators (as zero) and sets the cluster count to 8.
module kmeans_assign_accumulate #(
  parameter int NUM_CLUSTERS = 8,
  parameter int NUM_DIMS     = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  kaa_stream_if.sink                in_chan,
  kaa_stream_if.source              out_chan,
  input  logic                      cfg_wr_en,
  input  logic [kaa_pkg::CFG_W-1:0] cfg_wr_data
);
  import kaa_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  out_item_t  result;
  logic       in_ready;
  logic       out_valid;

  kaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kaa_datapath #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .NUM_DIMS     (NUM_DIMS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (in_chan.data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = result;
endmodule
